// File: sv/amcp_pkg.sv
// ----------------------------------------------------------------------------
// amcp_pkg
// Types and constants shared by the ASCII motor command line parser.
// ----------------------------------------------------------------------------
package amcp_pkg;

	// Parse phases: four tag letters, three numbers of three phases each
	// (before sign/digit, after sign, inside digits), then done.
	typedef logic [3:0] phase_t;

	localparam phase_t PH_TAG0    = 4'd0;
	localparam phase_t PH_NUM0    = 4'd4;
	localparam phase_t PH_LAST_DG = 4'd12;
	localparam phase_t PH_DONE    = 4'd13;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Number sub-phase
	localparam logic [1:0] SUB_LEAD  = 2'd0;
	localparam logic [1:0] SUB_SIGN  = 2'd1;
	localparam logic [1:0] SUB_DIGIT = 2'd2;

	// Number index
	localparam logic [1:0] NUM_SEQ   = 2'd0;
	localparam logic [1:0] NUM_LEFT  = 2'd1;
	localparam logic [1:0] NUM_RIGHT = 2'd2;

	// Bridge direction codes
	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	localparam logic [8:0] SPEED_SAT = 9'd256;
	localparam logic [7:0] DUTY_MAX  = 8'd255;

	typedef struct packed {
		logic [1:0] num;
		logic [1:0] sub;
		phase_t     base;
	} phase_dec_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] seq_number;
		logic [1:0]  left_direction;
		logic [7:0]  left_duty;
		logic [1:0]  right_direction;
		logic [7:0]  right_duty;
	} result_t;

	function automatic logic [7:0] tag_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h43;	// C
			2'd1: c = 8'h4D;	// M
			2'd2: c = 8'h44;	// D
			default: c = CH_COMMA;
		endcase
		return c;
	endfunction

	function automatic phase_dec_t phase_decode(input phase_t ph);
		phase_dec_t d;
		case (ph)
			4'd4:  d = '{num: NUM_SEQ,   sub: SUB_LEAD,  base: 4'd4};
			4'd5:  d = '{num: NUM_SEQ,   sub: SUB_SIGN,  base: 4'd4};
			4'd6:  d = '{num: NUM_SEQ,   sub: SUB_DIGIT, base: 4'd4};
			4'd7:  d = '{num: NUM_LEFT,  sub: SUB_LEAD,  base: 4'd7};
			4'd8:  d = '{num: NUM_LEFT,  sub: SUB_SIGN,  base: 4'd7};
			4'd9:  d = '{num: NUM_LEFT,  sub: SUB_DIGIT, base: 4'd7};
			4'd10: d = '{num: NUM_RIGHT, sub: SUB_LEAD,  base: 4'd10};
			4'd11: d = '{num: NUM_RIGHT, sub: SUB_SIGN,  base: 4'd10};
			4'd12: d = '{num: NUM_RIGHT, sub: SUB_DIGIT, base: 4'd10};
			default: d = '{num: NUM_SEQ, sub: SUB_LEAD, base: PH_NUM0};
		endcase
		return d;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
	endfunction

endpackage

// File: sv/ascii_motor_command_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_motor_command_parser_unit
// Parses "CMD,seq,left,right" lines from a byte stream into motor commands.
// ----------------------------------------------------------------------------
// One received character word is taken every clock cycle while in_stall is
// low. Each one updates the line parse state; a newline that ends a non-empty
// line loads one result word into a two-entry output buffer (output register
// plus skid register), which lets input flow on while a result waits;
// in_stall rises only when both entries are full. Rejected lines give
// accepted=0 with all other fields zero. Characters past LINE_MAX-1 in a
// line are ignored.
module ascii_motor_command_parser_unit
	import amcp_pkg::*;
#(
	parameter int LINE_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [31:0] seq_number,
	output logic [1:0]  left_direction,
	output logic [7:0]  left_duty,
	output logic [1:0]  right_direction,
	output logic [7:0]  right_duty
);

	localparam int CNT_W = $clog2(LINE_MAX);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_MAX - 1);

	// line parse state
	logic [CNT_W-1:0] char_count_q, char_count_nxt;
	phase_t           phase_q, phase_nxt;
	logic             failed_q, failed_nxt;
	logic             neg_q, neg_nxt;
	logic             digit_seen_q, digit_seen_nxt;
	logic [31:0]      accum_q, accum_nxt;
	logic [31:0]      held_seq_q, held_seq_nxt;
	logic [8:0]       held_left_q, held_left_nxt;

	logic       emit;
	result_t    res;
	phase_dec_t dec;
	logic       is_digit;
	logic [3:0] dval;
	logic [8:0] sat_in;
	logic [12:0] sat_mul;
	logic [7:0] right_mag;
	logic [7:0] left_mag;
	logic       line_ok;

	// output buffer
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    in_acc, out_take, produce;

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;
	assign produce  = in_acc && emit;

	assign dec      = phase_decode(phase_q);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign dval     = 4'(rx_byte - CH_ZERO);
	assign sat_in   = (accum_q > 32'(SPEED_SAT)) ? SPEED_SAT : accum_q[8:0];
	assign sat_mul  = {1'b0, sat_in, 3'b000} + {3'b000, sat_in, 1'b0} + 13'(dval);

	assign right_mag = (accum_q > 32'(DUTY_MAX)) ? DUTY_MAX : accum_q[7:0];
	assign left_mag  = held_left_q[8] ? 8'(-held_left_q) : held_left_q[7:0];
	assign line_ok   = !failed_q && ((phase_q == PH_DONE) || (phase_q == PH_LAST_DG));

	always_comb begin
		char_count_nxt = char_count_q;
		phase_nxt      = phase_q;
		failed_nxt     = failed_q;
		neg_nxt        = neg_q;
		digit_seen_nxt = digit_seen_q;
		accum_nxt      = accum_q;
		held_seq_nxt   = held_seq_q;
		held_left_nxt  = held_left_q;
		emit           = 1'b0;
		res            = '0;

		if (rx_byte == CH_CR) begin
			// drop
		end else if (rx_byte != CH_LF) begin
			if (char_count_q < CNT_LIMIT) begin
				char_count_nxt = char_count_q + CNT_W'(1);
				if (!failed_q && (phase_q < PH_DONE)) begin
					if (phase_q < PH_NUM0) begin
						if (rx_byte == tag_char(phase_q[1:0]))
							phase_nxt = phase_q + 4'd1;
						else
							failed_nxt = 1'b1;
					end else if (is_digit) begin
						if (dec.num == NUM_SEQ)
							accum_nxt = {accum_q[28:0], 3'b000} + {accum_q[30:0], 1'b0}
								+ 32'(dval);
						else
							accum_nxt = (sat_mul > 13'(SPEED_SAT)) ? 32'(SPEED_SAT)
								: 32'(sat_mul);
						digit_seen_nxt = 1'b1;
						phase_nxt      = dec.base + 4'd2;
					end else if ((dec.sub == SUB_LEAD) && is_blank(rx_byte)) begin
						// skip leading whitespace
					end else if ((dec.sub == SUB_LEAD) &&
							((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))) begin
						neg_nxt   = (rx_byte == CH_MINUS);
						phase_nxt = dec.base + 4'd1;
					end else if (dec.sub == SUB_DIGIT) begin
						if (dec.num == NUM_RIGHT) begin
							// hold accum and sign for the right motor
							phase_nxt = PH_DONE;
						end else if (rx_byte == CH_COMMA) begin
							if (dec.num == NUM_SEQ)
								held_seq_nxt = neg_q ? -accum_q : accum_q;
							else
								held_left_nxt = neg_q ? -{1'b0, right_mag}
									: {1'b0, right_mag};
							neg_nxt        = 1'b0;
							digit_seen_nxt = 1'b0;
							accum_nxt      = '0;
							phase_nxt      = dec.base + 4'd3;
						end else begin
							failed_nxt = 1'b1;
						end
					end else begin
						failed_nxt = 1'b1;
					end
				end
			end
		end else if (char_count_q != '0) begin
			emit = 1'b1;
			if (line_ok) begin
				res.accepted   = 1'b1;
				res.seq_number = held_seq_q;
				if (held_left_q == '0)
					res.left_direction = DIR_OFF;
				else if (held_left_q[8])
					res.left_direction = DIR_REV;
				else
					res.left_direction = DIR_FWD;
				res.left_duty = left_mag;
				if (right_mag == '0)
					res.right_direction = DIR_OFF;
				else if (neg_q)
					res.right_direction = DIR_REV;
				else
					res.right_direction = DIR_FWD;
				res.right_duty = right_mag;
			end
			// clear line
			char_count_nxt = '0;
			phase_nxt      = PH_TAG0;
			failed_nxt     = 1'b0;
			neg_nxt        = 1'b0;
			digit_seen_nxt = 1'b0;
			accum_nxt      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			phase_q      <= PH_TAG0;
			failed_q     <= 1'b0;
			neg_q        <= 1'b0;
			digit_seen_q <= 1'b0;
			accum_q      <= '0;
			held_seq_q   <= '0;
			held_left_q  <= '0;
		end else if (in_acc) begin
			char_count_q <= char_count_nxt;
			phase_q      <= phase_nxt;
			failed_q     <= failed_nxt;
			neg_q        <= neg_nxt;
			digit_seen_q <= digit_seen_nxt;
			accum_q      <= accum_nxt;
			held_seq_q   <= held_seq_nxt;
			held_left_q  <= held_left_nxt;
		end
	end

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (produce)
				out_q <= res;
		end else if (produce) begin
			skid_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = out_q.accepted;
	assign seq_number      = out_q.seq_number;
	assign left_direction  = out_q.left_direction;
	assign left_duty       = out_q.left_duty;
	assign right_direction = out_q.right_direction;
	assign right_duty      = out_q.right_duty;

endmodule
